/* rtl/core/lpht_pkg.sv */
// ============================================================================
// lpht_pkg - shared definitions for the linear probing hash table
// Widths, operation and status codes and the slot entry layout.
// ============================================================================
package lpht_pkg;

  localparam int KEY_W          = 31;
  localparam int FUNC_W         = 2;
  localparam int STATUS_W       = 2;
  localparam int SLOT_IDX_W     = 4;
  localparam int DEF_TABLE_SIZE = 16;

  localparam logic [FUNC_W-1:0] F_INS  = 2'd0;
  localparam logic [FUNC_W-1:0] F_REP  = 2'd1;
  localparam logic [FUNC_W-1:0] F_SRCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_INSERTED  = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
  } entry_t;

endpackage

/* rtl/core/lpht_mod.sv */
// ============================================================================
// lpht_mod - key modulo table size
// Reduces a key modulo the table size by multiplying with a rounded-up
// reciprocal; the low quotient bits and then the remainder are registered.
// ============================================================================
module lpht_mod
  import lpht_pkg::*;
#(
  parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [KEY_W-1:0]              value,
  output logic                          done,
  output logic [$clog2(TABLE_SIZE)-1:0] rem
);

  localparam int RW = $clog2(TABLE_SIZE);
  localparam int QS = KEY_W + RW;
  localparam int PW = 2 * KEY_W + 1;
  // With the reciprocal rounded up, the quotient is exact for every key.
  localparam logic [63:0] RECIP64 =
    ((64'd1 << QS) + 64'(TABLE_SIZE) - 64'd1) / 64'(TABLE_SIZE);
  localparam logic [KEY_W:0]  RECIP = RECIP64[KEY_W:0];
  localparam logic [RW-1:0]   N_LO  = RW'(TABLE_SIZE);

  logic [PW-1:0] prod;
  logic [RW-1:0] q_lo_r, key_lo_r;
  logic [RW-1:0] qn;
  logic [RW-1:0] rem_r, rem_nxt;
  logic          step_r, done_r;

  assign prod = PW'(value) * PW'(RECIP);

  // The remainder is below 2^RW, so only the low bits of the quotient count.
  assign qn      = q_lo_r * N_LO;
  assign rem_nxt = key_lo_r - qn;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= start;
      done_r <= step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_lo_r   <= prod[QS+RW-1:QS];
      key_lo_r <= value[RW-1:0];
    end
    if (step_r) begin
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

/* rtl/core/linear_probe_hash_table.sv */
// ============================================================================
// linear_probe_hash_table - open addressing hash table, linear probing
// Insert, insert with replacement and search of 31-bit keys in one table.
// ============================================================================
// Usage. Each input transaction carries an operation (in_func) and a key
// (in_key); each one yields exactly one output transaction carrying a status
// and the low four bits of the slot concerned. Both channels use valid and
// stall, and a transaction moves at an edge with valid high and stall low.
//
// Operation. The home slot is found by multiplying the key with a
// rounded-up reciprocal of the table size. A search then streams one read
// of the slot memory per cycle. An insert reads home, streams up to
// TABLE_SIZE - 1 reads looking for a free slot and, for replacement, runs
// the reduction again on the displaced key. The single read port of the
// slot memory sets the pace of the probe. One operation is in flight at a
// time.
//
// Reset. After rst_n the block sweeps the slot memory, one slot per cycle,
// holding in_stall high, so the table starts empty.
//
// Stalls. The result sits in an output register; while out_stall is high
// the block may still take and work on the next transaction, and waits
// only when its next result is ready and the register is still full.
// ============================================================================
module linear_probe_hash_table
  import lpht_pkg::*;
#(
  parameter int TABLE_SIZE = DEF_TABLE_SIZE
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [KEY_W-1:0]      in_key,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [SLOT_IDX_W-1:0] out_slot_index
);

  localparam int SW = $clog2(TABLE_SIZE);
  localparam int CW = $clog2(TABLE_SIZE + 1);
  localparam logic [SW-1:0] LAST_SLOT = SW'(TABLE_SIZE - 1);

  // State codes.
  localparam logic [3:0] S_CLR  = 4'd0;
  localparam logic [3:0] S_IDLE = 4'd1;
  localparam logic [3:0] S_HMOD = 4'd2;
  localparam logic [3:0] S_HRD  = 4'd3;
  localparam logic [3:0] S_HCHK = 4'd4;
  localparam logic [3:0] S_SRCH = 4'd5;
  localparam logic [3:0] S_FREE = 4'd6;
  localparam logic [3:0] S_OMOD = 4'd7;
  localparam logic [3:0] S_WRH  = 4'd8;
  localparam logic [3:0] S_RESP = 4'd9;

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
    return (s == LAST_SLOT) ? '0 : s + 1'b1;
  endfunction

  logic [3:0]          state_r, state_nxt;
  logic [SW-1:0]       clr_r, clr_nxt;
  logic [FUNC_W-1:0]   func_r;
  logic [KEY_W-1:0]    key_r, occ_r, occ_nxt;
  logic [SW-1:0]       home_r, home_nxt;
  logic [SW-1:0]       fr_r, fr_nxt;
  logic [SW-1:0]       pa_r, pa_nxt;
  logic [SW-1:0]       pend_slot_r, pend_slot_nxt;
  logic [CW-1:0]       ic_r, ic_nxt;
  logic                pend_r, pend_nxt;
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [SW-1:0]       res_slot_r, res_slot_nxt;

  logic                  out_valid_r;
  logic [STATUS_W-1:0]   out_status_r;
  logic [SLOT_IDX_W-1:0] out_slot_r;

  // Slot memory: valid flag and key per slot, one write and one read port.
  entry_t        mem [TABLE_SIZE];
  entry_t        rd_data_r;
  logic [SW-1:0] rd_addr;
  logic          wr_en;
  logic [SW-1:0] wr_addr;
  entry_t        wr_data;

  logic             mod_start;
  logic [KEY_W-1:0] mod_val;
  logic             mod_done;
  logic [SW-1:0]    mod_rem;

  logic          in_acc;
  logic          load_out;
  logic [CW-1:0] limit;
  logic          probe_hit;
  logic          probe_miss;

  lpht_mod #(
    .TABLE_SIZE(TABLE_SIZE)
  ) u_mod (
    .clk  (clk),
    .rst_n(rst_n),
    .start(mod_start),
    .value(mod_val),
    .done (mod_done),
    .rem  (mod_rem)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign load_out = (state_r == S_RESP) && (!out_valid_r || !out_stall);

  // A search walks every slot from home; a free slot search walks the others.
  assign limit = (state_r == S_SRCH) ? CW'(TABLE_SIZE) : CW'(TABLE_SIZE - 1);

  // The read issued last cycle is checked against its own slot number.
  assign probe_hit = pend_r && ((state_r == S_SRCH)
                                ? (rd_data_r.valid && (rd_data_r.key == key_r))
                                : !rd_data_r.valid);
  assign probe_miss = !pend_r && (ic_r == limit);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    home_nxt       = home_r;
    occ_nxt        = occ_r;
    fr_nxt         = fr_r;
    pa_nxt         = pa_r;
    pend_slot_nxt  = pend_slot_r;
    ic_nxt         = ic_r;
    pend_nxt       = pend_r;
    res_status_nxt = res_status_r;
    res_slot_nxt   = res_slot_r;
    rd_addr        = pa_r;
    wr_en          = 1'b0;
    wr_addr        = fr_r;
    wr_data        = '{valid: 1'b1, key: key_r};
    mod_start      = 1'b0;
    mod_val        = in_key;

    unique case (state_r)
      S_CLR: begin
        wr_en   = 1'b1;
        wr_addr = clr_r;
        wr_data = '{valid: 1'b0, key: '0};
        clr_nxt = next_slot(clr_r);
        if (clr_r == LAST_SLOT) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          if (in_func == F_INS || in_func == F_REP || in_func == F_SRCH) begin
            mod_start = 1'b1;
            state_nxt = S_HMOD;
          end else begin
            // Unused operation code: nothing changes.
            res_status_nxt = ST_NOT_FOUND;
            res_slot_nxt   = '0;
            state_nxt      = S_RESP;
          end
        end
      end
      S_HMOD: begin
        if (mod_done) begin
          home_nxt = mod_rem;
          pa_nxt   = mod_rem;
          ic_nxt   = '0;
          pend_nxt = 1'b0;
          state_nxt = (func_r == F_SRCH) ? S_SRCH : S_HRD;
        end
      end
      S_HRD: begin
        rd_addr   = home_r;
        state_nxt = S_HCHK;
      end
      S_HCHK: begin
        if (!rd_data_r.valid) begin
          wr_en          = 1'b1;
          wr_addr        = home_r;
          res_status_nxt = ST_INSERTED;
          res_slot_nxt   = home_r;
          state_nxt      = S_RESP;
        end else begin
          occ_nxt   = rd_data_r.key;
          pa_nxt    = next_slot(home_r);
          ic_nxt    = '0;
          pend_nxt  = 1'b0;
          state_nxt = S_FREE;
        end
      end
      S_SRCH, S_FREE: begin
        if (ic_r != limit) begin
          pa_nxt        = next_slot(pa_r);
          ic_nxt        = ic_r + 1'b1;
          pend_nxt      = 1'b1;
          pend_slot_nxt = pa_r;
        end else begin
          pend_nxt = 1'b0;
        end
        if (probe_hit) begin
          if (state_r == S_SRCH) begin
            res_status_nxt = ST_FOUND;
            res_slot_nxt   = pend_slot_r;
            state_nxt      = S_RESP;
          end else if (func_r == F_REP) begin
            // The occupant's own home decides who moves.
            fr_nxt    = pend_slot_r;
            mod_start = 1'b1;
            mod_val   = occ_r;
            state_nxt = S_OMOD;
          end else begin
            wr_en          = 1'b1;
            wr_addr        = pend_slot_r;
            res_status_nxt = ST_INSERTED;
            res_slot_nxt   = pend_slot_r;
            state_nxt      = S_RESP;
          end
        end else if (probe_miss) begin
          res_status_nxt = (state_r == S_SRCH) ? ST_NOT_FOUND : ST_FULL;
          res_slot_nxt   = '0;
          state_nxt      = S_RESP;
        end
      end
      S_OMOD: begin
        if (mod_done) begin
          wr_en = 1'b1;
          if (mod_rem != home_r) begin
            wr_data   = '{valid: 1'b1, key: occ_r};
            state_nxt = S_WRH;
          end else begin
            res_status_nxt = ST_INSERTED;
            res_slot_nxt   = fr_r;
            state_nxt      = S_RESP;
          end
        end
      end
      S_WRH: begin
        wr_en          = 1'b1;
        wr_addr        = home_r;
        res_status_nxt = ST_INSERTED;
        res_slot_nxt   = home_r;
        state_nxt      = S_RESP;
      end
      S_RESP: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      pend_r  <= 1'b0;
      ic_r    <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      pend_r  <= pend_nxt;
      ic_r    <= ic_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      func_r <= in_func;
      key_r  <= in_key;
    end
    home_r       <= home_nxt;
    occ_r        <= occ_nxt;
    fr_r         <= fr_nxt;
    pa_r         <= pa_nxt;
    pend_slot_r  <= pend_slot_nxt;
    res_status_r <= res_status_nxt;
    res_slot_r   <= res_slot_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // Output register: the next transaction may be worked on while it waits.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= res_status_r;
      out_slot_r   <= SLOT_IDX_W'(res_slot_r);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_slot_index = out_slot_r;

  // A found result only ever comes from a search.
  a_found_from_search: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && (res_status_r == ST_FOUND) |-> (func_r == F_SRCH))
    else $error("found status from a non-search operation");

  // A full table is only reported for an insert.
  a_full_from_insert: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && (res_status_r == ST_FULL) |-> (func_r == F_INS || func_r == F_REP))
    else $error("full status from a non-insert operation");

  // The reduction finishes only while the controller waits for it.
  a_mod_done_expected: assert property (@(posedge clk) disable iff (!rst_n)
    mod_done |-> (state_r == S_HMOD || state_r == S_OMOD))
    else $error("home slot reduction finished unexpectedly");

  // The slot memory is never written while idle or holding a result.
  a_no_idle_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE || state_r == S_RESP) |-> !wr_en)
    else $error("slot memory written outside an operation");

endmodule
